// ----- hw/rtl/cau_pkg.sv -----
// Shared types, codes and constants of the complex arithmetic unit.
// Used by cau_front, cau_queue, cau_back and complex_arithmetic_unit; no dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Exact product and sum widths
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = 2 * DATA_WIDTH + 1;
    // Scaled dividend and quotient width
    localparam int QUO_W  = 2 * DATA_WIDTH + FRAC_BITS;
    // Input width of the saturation function fit_sat
    localparam int FIT_W  = QUO_W + 1;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Operation codes on the func field
    localparam logic [1:0] FN_ADD = 2'd0;
    localparam logic [1:0] FN_MUL = 2'd1;
    localparam logic [1:0] FN_DIV = 2'd2;
    localparam logic [1:0] FN_MAG = 2'd3;

    // Request classes decided by the front end
    localparam logic [2:0] CLS_ADD = 3'd0;
    localparam logic [2:0] CLS_MUL = 3'd1;
    localparam logic [2:0] CLS_DIV = 3'd2;
    localparam logic [2:0] CLS_MAG = 3'd3;
    localparam logic [2:0] CLS_DZ  = 3'd4;

    // Status codes
    localparam logic [1:0] STS_OK  = 2'd0;
    localparam logic [1:0] STS_SAT = 2'd1;
    localparam logic [1:0] STS_DZ  = 2'd2;

    localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINP = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [2:0]                   cls;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } cau_req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  sat;
    } fit_t;

    // Saturate a wide signed value to DATA_WIDTH bits
    function automatic fit_t fit_sat(input logic signed [FIT_W-1:0] v);
        fit_t r;
        logic [FIT_W-DATA_WIDTH:0] top;
        top = v[FIT_W-1:DATA_WIDTH-1];
        if (top == '0 || top == '1) begin
            r.value = v[DATA_WIDTH-1:0];
            r.sat   = 1'b0;
        end else begin
            r.value = v[FIT_W-1] ? MINP : MAXP;
            r.sat   = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cau_front.sv -----
// Front end: takes input requests and classifies them for the back end.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic signed [DATA_WIDTH-1:0] s_a_real,
    input  logic signed [DATA_WIDTH-1:0] s_a_imag,
    input  logic signed [DATA_WIDTH-1:0] s_b_real,
    input  logic signed [DATA_WIDTH-1:0] s_b_imag,
    output logic                   push,
    output cau_req_t               push_req,
    input  logic                   q_full
);

    logic [2:0] cls;

    // Classify: a division by a zero divisor needs no arithmetic at all
    always_comb begin
        case (s_func)
            FN_ADD:  cls = CLS_ADD;
            FN_MUL:  cls = CLS_MUL;
            FN_DIV:  cls = (s_b_real == '0 && s_b_imag == '0) ? CLS_DZ : CLS_DIV;
            FN_MAG:  cls = CLS_MAG;
            default: cls = CLS_ADD;
        endcase
    end

    assign s_ready           = ~q_full;
    assign push              = s_valid & ~q_full;
    assign push_req.cls      = cls;
    assign push_req.a_real   = s_a_real;
    assign push_req.a_imag   = s_a_imag;
    assign push_req.b_real   = s_b_real;
    assign push_req.b_imag   = s_b_imag;

    // A request is pushed only while the queue has room
    property p_push_needs_room;
        @(posedge aclk) disable iff (!aresetn) push |-> !q_full;
    endproperty
    a_push_needs_room: assert property (p_push_needs_room) else $error("push into full queue");

    property p_dz_only_div;
        @(posedge aclk) disable iff (!aresetn) (push && push_req.cls == CLS_DZ) |-> s_func == FN_DIV;
    endproperty
    a_dz_only_div: assert property (p_dz_only_div) else $error("zero divisor on non-divide");

    property p_dz_zero_b;
        @(posedge aclk) disable iff (!aresetn)
            (push && push_req.cls == CLS_DZ) |-> (s_b_real == '0 && s_b_imag == '0);
    endproperty
    a_dz_zero_b: assert property (p_dz_zero_b) else $error("zero divisor misclassified");

endmodule

// ----- hw/rtl/cau_queue.sv -----
// Short request queue between front end and back end.
// Depends on cau_pkg.
module cau_queue import cau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  cau_req_t push_req,
    output logic     q_full,
    input  logic     pop,
    output logic     q_valid,
    output cau_req_t head
);

    cau_req_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign q_full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    // Write entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    property p_no_pop_empty;
        @(posedge aclk) disable iff (!aresetn) pop |-> q_valid;
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) count_reg <= (QPTR_W+1)'(QDEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("queue count overrun");

    property p_ptr_gap;
        @(posedge aclk) disable iff (!aresetn)
            wr_ptr_reg == QPTR_W'(rd_ptr_reg + count_reg[QPTR_W-1:0]);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers out of step");

endmodule

// ----- hw/rtl/cau_back.sv -----
// Back end: carries out one request at a time with a shared multiplier,
// a bit-serial divider pair and a digit-serial square root. Depends on cau_pkg.
module cau_back import cau_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  cau_req_t              head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_res_real,
    output logic [DATA_WIDTH-1:0] m_res_imag,
    output logic [1:0]            m_status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [1:0] SEL_AR = 2'd0;
    localparam logic [1:0] SEL_AI = 2'd1;
    localparam logic [1:0] SEL_BR = 2'd2;
    localparam logic [1:0] SEL_BI = 2'd3;

    localparam logic [1:0] TGT_A = 2'd0;
    localparam logic [1:0] TGT_B = 2'd1;
    localparam logic [1:0] TGT_D = 2'd2;

    localparam int RMW = 2 * DATA_WIDTH + 1;
    localparam int SRW = DATA_WIDTH + 2;

    typedef struct packed {
        logic [1:0] xs;
        logic [1:0] ys;
        logic [1:0] tgt;
        logic       neg;
    } mac_op_t;

    // Product schedule of each operation
    function automatic mac_op_t mac_plan(input logic [2:0] cls, input logic [2:0] step);
        mac_op_t m;
        m = '{xs: SEL_AR, ys: SEL_BR, tgt: TGT_A, neg: 1'b0};
        case (cls)
            CLS_MUL: begin
                case (step)
                    3'd0:    m = '{xs: SEL_AR, ys: SEL_BR, tgt: TGT_A, neg: 1'b0};
                    3'd1:    m = '{xs: SEL_AI, ys: SEL_BI, tgt: TGT_A, neg: 1'b1};
                    3'd2:    m = '{xs: SEL_AR, ys: SEL_BI, tgt: TGT_B, neg: 1'b0};
                    default: m = '{xs: SEL_AI, ys: SEL_BR, tgt: TGT_B, neg: 1'b0};
                endcase
            end
            CLS_DIV: begin
                case (step)
                    3'd0:    m = '{xs: SEL_AR, ys: SEL_BR, tgt: TGT_A, neg: 1'b0};
                    3'd1:    m = '{xs: SEL_AI, ys: SEL_BI, tgt: TGT_A, neg: 1'b0};
                    3'd2:    m = '{xs: SEL_AI, ys: SEL_BR, tgt: TGT_B, neg: 1'b0};
                    3'd3:    m = '{xs: SEL_AR, ys: SEL_BI, tgt: TGT_B, neg: 1'b1};
                    3'd4:    m = '{xs: SEL_BR, ys: SEL_BR, tgt: TGT_D, neg: 1'b0};
                    default: m = '{xs: SEL_BI, ys: SEL_BI, tgt: TGT_D, neg: 1'b0};
                endcase
            end
            default: begin
                case (step)
                    3'd0:    m = '{xs: SEL_AR, ys: SEL_AR, tgt: TGT_D, neg: 1'b0};
                    default: m = '{xs: SEL_AI, ys: SEL_AI, tgt: TGT_D, neg: 1'b0};
                endcase
            end
        endcase
        return m;
    endfunction

    logic [2:0]                   state_reg;
    logic [2:0]                   cls_reg;
    logic signed [DATA_WIDTH-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic [2:0]                   mstep_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         prod_vld_reg;
    logic [1:0]                   tgt_reg;
    logic                         neg_reg;
    logic signed [ACC_W-1:0]      acc_a_reg, acc_b_reg, acc_d_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [QUO_W-1:0]             n_re_reg, n_im_reg, q_re_reg, q_im_reg;
    logic [PROD_W-1:0]            den_reg;
    logic                         neg_re_reg, neg_im_reg;
    logic [RMW-1:0]               rem_re_reg, rem_im_reg;
    logic [PROD_W-1:0]            s_reg;
    logic [SRW-1:0]               srem_reg;
    logic [DATA_WIDTH-1:0]        root_reg;
    logic                         m_valid_reg;
    logic [DATA_WIDTH-1:0]        res_real_reg, res_imag_reg;
    logic [1:0]                   status_reg;

    logic                         out_free;
    logic [2:0]                   mac_len;
    mac_op_t                      plan;
    logic signed [DATA_WIDTH-1:0] mx, my;
    logic signed [ACC_W-1:0]      term;
    logic [RMW-1:0]               rre_sh, rim_sh, den_ext;
    logic                         re_ge, im_ge;
    logic [SRW-1:0]               srem_sh, strial;
    logic                         s_ge;
    logic [PROD_W-1:0]            mag_a, mag_b;
    fit_t                         add_re, add_im, fin_re, fin_im;
    logic [1:0]                   fin_status;
    logic signed [ACC_W-1:0]      sh_a, sh_b;

    assign out_free = ~m_valid_reg | m_ready;
    assign pop      = (state_reg == ST_IDLE) & q_valid & out_free;

    always_comb begin
        case (cls_reg)
            CLS_MUL: mac_len = 3'd4;
            CLS_DIV: mac_len = 3'd6;
            default: mac_len = 3'd2;
        endcase
    end

    // Select multiplier operands for the current step
    assign plan = mac_plan(cls_reg, mstep_reg);
    always_comb begin
        case (plan.xs)
            SEL_AR:  mx = ar_reg;
            SEL_AI:  mx = ai_reg;
            SEL_BR:  mx = br_reg;
            default: mx = bi_reg;
        endcase
        case (plan.ys)
            SEL_AR:  my = ar_reg;
            SEL_AI:  my = ai_reg;
            SEL_BR:  my = br_reg;
            default: my = bi_reg;
        endcase
    end

    assign term = neg_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);

    // Restoring division steps, one quotient bit each for both parts
    assign den_ext = {1'b0, den_reg};
    assign rre_sh  = {rem_re_reg[RMW-2:0], n_re_reg[QUO_W-1]};
    assign rim_sh  = {rem_im_reg[RMW-2:0], n_im_reg[QUO_W-1]};
    assign re_ge   = rre_sh >= den_ext;
    assign im_ge   = rim_sh >= den_ext;

    // Square root step, one root bit per cycle
    assign srem_sh = {srem_reg[SRW-3:0], s_reg[PROD_W-1:PROD_W-2]};
    assign strial  = {root_reg, 2'b01};
    assign s_ge    = srem_sh >= strial;

    assign mag_a = acc_a_reg[ACC_W-1] ? PROD_W'(-acc_a_reg) : acc_a_reg[PROD_W-1:0];
    assign mag_b = acc_b_reg[ACC_W-1] ? PROD_W'(-acc_b_reg) : acc_b_reg[PROD_W-1:0];

    // Addition result straight from the queue head
    assign add_re = fit_sat(FIT_W'(head.a_real) + FIT_W'(head.b_real));
    assign add_im = fit_sat(FIT_W'(head.a_imag) + FIT_W'(head.b_imag));

    // Final truncation and saturation of the long operations
    assign sh_a = acc_a_reg >>> FRAC_BITS;
    assign sh_b = acc_b_reg >>> FRAC_BITS;
    always_comb begin
        case (cls_reg)
            CLS_MUL: begin
                fin_re = fit_sat(FIT_W'(sh_a));
                fin_im = fit_sat(FIT_W'(sh_b));
            end
            CLS_DIV: begin
                fin_re = fit_sat(neg_re_reg ? -FIT_W'({1'b0, q_re_reg})
                                            : FIT_W'({1'b0, q_re_reg}));
                fin_im = fit_sat(neg_im_reg ? -FIT_W'({1'b0, q_im_reg})
                                            : FIT_W'({1'b0, q_im_reg}));
            end
            default: begin
                fin_re.value = root_reg[DATA_WIDTH-1] ? MAXP : root_reg;
                fin_re.sat   = root_reg[DATA_WIDTH-1];
                fin_im.value = '0;
                fin_im.sat   = 1'b0;
            end
        endcase
        fin_status = (fin_re.sat | fin_im.sat) ? STS_SAT : STS_OK;
    end

    // Sequence one request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            prod_vld_reg <= (state_reg == ST_MAC) && (mstep_reg < mac_len);
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        case (head.cls)
                            CLS_ADD: begin
                                m_valid_reg <= 1'b1;
                                res_real_reg <= add_re.value;
                                res_imag_reg <= add_im.value;
                                status_reg   <= (add_re.sat | add_im.sat) ? STS_SAT : STS_OK;
                            end
                            CLS_DZ: begin
                                m_valid_reg  <= 1'b1;
                                res_real_reg <= '0;
                                res_imag_reg <= '0;
                                status_reg   <= STS_DZ;
                            end
                            default: state_reg <= ST_MAC;
                        endcase
                    end
                end
                ST_MAC: begin
                    if (mstep_reg == mac_len) begin
                        state_reg <= (cls_reg == CLS_MUL) ? ST_DONE : ST_LOAD;
                    end
                end
                ST_LOAD: state_reg <= (cls_reg == CLS_DIV) ? ST_DIV : ST_SQRT;
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(QUO_W - 1)) state_reg <= ST_DONE;
                end
                ST_SQRT: begin
                    if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        res_real_reg <= fin_re.value;
                        res_imag_reg <= fin_im.value;
                        status_reg   <= fin_status;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            cls_reg   <= head.cls;
            ar_reg    <= head.a_real;
            ai_reg    <= head.a_imag;
            br_reg    <= head.b_real;
            bi_reg    <= head.b_imag;
            mstep_reg <= '0;
            acc_a_reg <= '0;
            acc_b_reg <= '0;
            acc_d_reg <= '0;
        end
        if (state_reg == ST_MAC) begin
            prod_reg  <= mx * my;
            tgt_reg   <= plan.tgt;
            neg_reg   <= plan.neg;
            mstep_reg <= mstep_reg + 1'b1;
        end
        if (prod_vld_reg) begin
            case (tgt_reg)
                TGT_A:   acc_a_reg <= acc_a_reg + term;
                TGT_B:   acc_b_reg <= acc_b_reg + term;
                default: acc_d_reg <= acc_d_reg + term;
            endcase
        end
        case (state_reg)
            ST_LOAD: begin
                cnt_reg    <= '0;
                n_re_reg   <= {mag_a, {FRAC_BITS{1'b0}}};
                n_im_reg   <= {mag_b, {FRAC_BITS{1'b0}}};
                neg_re_reg <= acc_a_reg[ACC_W-1];
                neg_im_reg <= acc_b_reg[ACC_W-1];
                den_reg    <= acc_d_reg[PROD_W-1:0];
                rem_re_reg <= '0;
                rem_im_reg <= '0;
                s_reg      <= acc_d_reg[PROD_W-1:0];
                srem_reg   <= '0;
                root_reg   <= '0;
            end
            ST_DIV: begin
                cnt_reg    <= cnt_reg + 1'b1;
                n_re_reg   <= {n_re_reg[QUO_W-2:0], 1'b0};
                n_im_reg   <= {n_im_reg[QUO_W-2:0], 1'b0};
                rem_re_reg <= re_ge ? rre_sh - den_ext : rre_sh;
                rem_im_reg <= im_ge ? rim_sh - den_ext : rim_sh;
                q_re_reg   <= {q_re_reg[QUO_W-2:0], re_ge};
                q_im_reg   <= {q_im_reg[QUO_W-2:0], im_ge};
            end
            ST_SQRT: begin
                cnt_reg  <= cnt_reg + 1'b1;
                s_reg    <= {s_reg[PROD_W-3:0], 2'b00};
                srem_reg <= s_ge ? srem_sh - strial : srem_sh;
                root_reg <= {root_reg[DATA_WIDTH-2:0], s_ge};
            end
            default: ;
        endcase
        if (state_reg == ST_LOAD) begin
            q_re_reg <= '0;
            q_im_reg <= '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_res_real = res_real_reg;
    assign m_res_imag = res_imag_reg;
    assign m_status   = status_reg;

    property p_pop_idle;
        @(posedge aclk) disable iff (!aresetn) pop |-> state_reg == ST_IDLE;
    endproperty
    a_pop_idle: assert property (p_pop_idle) else $error("request taken while busy");

    property p_dz_zero;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_status == STS_DZ) |-> (m_res_real == '0 && m_res_imag == '0);
    endproperty
    a_dz_zero: assert property (p_dz_zero) else $error("zero divisor result not zero");

    property p_done_drains;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_DONE && out_free) |=> (m_valid && state_reg == ST_IDLE);
    endproperty
    a_done_drains: assert property (p_done_drains) else $error("finished result lost");

endmodule

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Top level of the complex arithmetic unit.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.

// Complex add, multiply, divide and magnitude on signed Q16.16 operands, with
// saturation flagged in status. A request is accepted every cycle while the
// four-entry queue has room; the back end then takes one request at a time:
// an addition or a division by a zero divisor is answered straight from the
// queue head, a multiplication takes four products through the single 32x32
// multiplier, then scaling, a magnitude two products, then one root bit per
// cycle, and a division six products, then one quotient bit per cycle over
// 80 bits. Sustained rate is therefore set by the mix of operations; the
// back end starts the next request only once the result register is free or
// is being emptied in the same cycle, while the queue keeps taking requests.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic signed [DATA_WIDTH-1:0] s_a_real,
    input  logic signed [DATA_WIDTH-1:0] s_a_imag,
    input  logic signed [DATA_WIDTH-1:0] s_b_real,
    input  logic signed [DATA_WIDTH-1:0] s_b_imag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_res_real,
    output logic signed [DATA_WIDTH-1:0] m_res_imag,
    output logic [1:0]                   m_status
);

    logic     push, q_full, pop, q_valid;
    cau_req_t push_req, head;

    // Accept and classify
    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_a_real (s_a_real),
        .s_a_imag (s_a_imag),
        .s_b_real (s_b_real),
        .s_b_imag (s_b_imag),
        .push     (push),
        .push_req (push_req),
        .q_full   (q_full)
    );

    // Hold requests between the two sides
    cau_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .q_full   (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    // Carry out requests
    cau_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_real (m_res_real),
        .m_res_imag (m_res_imag),
        .m_status   (m_status)
    );

endmodule
